### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(name, clk, rst, prop)
`define ASSERT_NEVER(name, clk, rst, expr)

`endif

`endif

### rtl/efd_pkg.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder package
// Payload structs, classified item record, result kinds and register map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package efd_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      KIND_PAYLOAD  = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_ABORTED  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      REG_SOF_CHAR      = 3'd0,
      REG_EOF_CHAR      = 3'd1,
      REG_ESC_CHAR      = 3'd2,
      REG_LEGAL_LOW     = 3'd3,
      REG_LEGAL_HIGH    = 3'd4,
      REG_MAX_FRAME_LEN = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       line_error;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  payload;
      logic [15:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  sof_char;
      logic [7:0]  eof_char;
      logic [7:0]  esc_char;
      logic [7:0]  legal_low;
      logic [7:0]  legal_high;
      logic [15:0] max_frame_len;
   } cfg_type;

   // one received byte with its compare results, state independent
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       line_error;
      logic       is_sof;
      logic       is_eof;
      logic       is_esc;
      logic       legal;
   } class_type;

endpackage

### rtl/efd_front.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder front end
// Accepts received bytes and tags them against the special characters and
// the legal range before they enter the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efd_front import efd_pkg::*; (
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  cfg_type   cfg,
   input  logic      queue_full,
   output logic      push,
   output class_type push_data
);

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   always_comb begin
      push_data.rx_byte    = req_data.rx_byte;
      push_data.line_error = req_data.line_error;
      push_data.is_sof     = (req_data.rx_byte == cfg.sof_char);
      push_data.is_eof     = (req_data.rx_byte == cfg.eof_char);
      push_data.is_esc     = (req_data.rx_byte == cfg.esc_char);
      push_data.legal      = (req_data.rx_byte >= cfg.legal_low) &&
                             (req_data.rx_byte <= cfg.legal_high);
   end

endmodule

### rtl/efd_queue.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder queue
// Short FIFO of classified items between front end and frame engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module efd_queue import efd_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  class_type push_data,
   input  logic      pop,
   output class_type pop_data,
   output logic      full,
   output logic      empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   class_type        entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/efd_back.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder frame engine
// Holds the frame state, applies the deframing rules to each queued item
// and registers the result towards the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module efd_back import efd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  class_type entry,
   input  logic      queue_empty,
   output logic      pop,
   input  logic [15:0] max_frame_len,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_data
);

   logic        inside_ff, inside_in;
   logic        esc_ff, esc_in;
   logic [15:0] count_ff, count_in;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic        emit;
   kind_type    res_kind;
   logic [7:0]  res_byte;
   logic [15:0] res_len;

   assign pop       = !queue_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      inside_in = inside_ff;
      esc_in    = esc_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      res_kind  = KIND_ABORTED;
      res_byte  = '0;
      res_len   = count_ff;
      priority if (entry.line_error) begin
         emit      = inside_ff;
         inside_in = 1'b0;
         esc_in    = 1'b0;
         count_in  = '0;
      end else if (!inside_ff) begin
         if (entry.is_sof) begin
            inside_in = 1'b1;
            esc_in    = 1'b0;
            count_in  = '0;
         end
      end else if (!entry.legal) begin
         emit      = 1'b1;
         inside_in = 1'b0;
         esc_in    = 1'b0;
         count_in  = '0;
      end else if (!esc_ff && entry.is_eof) begin
         emit      = 1'b1;
         res_kind  = KIND_COMPLETE;
         inside_in = 1'b0;
         count_in  = '0;
      end else if (!esc_ff && entry.is_esc) begin
         esc_in = 1'b1;
      end else if (count_ff < max_frame_len) begin
         // literal after escape or plain data byte
         emit     = 1'b1;
         res_kind = KIND_PAYLOAD;
         res_byte = entry.rx_byte;
         res_len  = count_ff + 16'd1;
         esc_in   = 1'b0;
         count_in = count_ff + 16'd1;
      end else begin
         // length limit hit: drop
         emit      = 1'b1;
         inside_in = 1'b0;
         esc_in    = 1'b0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b0;
         esc_ff       <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            inside_ff <= inside_in;
            esc_ff    <= esc_in;
            count_ff  <= count_in;
         end
         rsp_valid_ff <= (rsp_valid_ff && rsp_stall) || (pop && emit);
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_data_ff.kind         <= res_kind;
         rsp_data_ff.payload      <= res_byte;
         rsp_data_ff.frame_length <= res_len;
      end
   end

   `ASSERT_PROP(a_idle_state_clear, clock, reset, !inside_ff |-> (count_ff == '0 && !esc_ff))
   `ASSERT_PROP(a_payload_len_nonzero, clock, reset, (rsp_valid_ff && rsp_data_ff.kind == KIND_PAYLOAD) |-> rsp_data_ff.frame_length != '0)
   `ASSERT_PROP(a_status_byte_zero, clock, reset, (rsp_valid_ff && rsp_data_ff.kind != KIND_PAYLOAD) |-> rsp_data_ff.payload == '0)
   `ASSERT_PROP(a_close_leaves_frame, clock, reset, (pop && emit && res_kind != KIND_PAYLOAD) |=> !inside_ff)

endmodule

### rtl/escaped_frame_decoder.sv
// Byte-stuffed frame decoder. Each accepted item is one received byte (or a
// line error); results are payload bytes, frame-complete and frame-aborted
// reports carrying the running or final payload length. The block sustains
// one item per clock while no result is stalled: a front end tags each byte
// against the start, end and escape characters and the legal range, a short
// queue decouples it from the frame engine, whose state update sets the rate.
// An accepted item is written into the queue, popped by the engine, and its
// result is held in the output register until taken; items that produce no
// result (bytes outside a frame, escape characters) still pass through the
// engine. The input stalls only once the queue has filled behind a stalled
// result. Registers should be written only while no item is in flight.
// ----------------------------------------------------------------------------
// Escaped frame decoder top level
// Configuration registers, front end, queue and frame engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escaped_frame_decoder import efd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_index;
   logic          csr_write;

   class_type     push_data;
   class_type     pop_data;
   logic          push;
   logic          pop;
   logic          queue_full;
   logic          queue_empty;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_SOF_CHAR:      cfg_in.sof_char      = csr_pwdata[7:0];
            REG_EOF_CHAR:      cfg_in.eof_char      = csr_pwdata[7:0];
            REG_ESC_CHAR:      cfg_in.esc_char      = csr_pwdata[7:0];
            REG_LEGAL_LOW:     cfg_in.legal_low     = csr_pwdata[7:0];
            REG_LEGAL_HIGH:    cfg_in.legal_high    = csr_pwdata[7:0];
            REG_MAX_FRAME_LEN: cfg_in.max_frame_len = csr_pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_SOF_CHAR:      csr_prdata = CSR_DATA_W'(cfg_ff.sof_char);
         REG_EOF_CHAR:      csr_prdata = CSR_DATA_W'(cfg_ff.eof_char);
         REG_ESC_CHAR:      csr_prdata = CSR_DATA_W'(cfg_ff.esc_char);
         REG_LEGAL_LOW:     csr_prdata = CSR_DATA_W'(cfg_ff.legal_low);
         REG_LEGAL_HIGH:    csr_prdata = CSR_DATA_W'(cfg_ff.legal_high);
         REG_MAX_FRAME_LEN: csr_prdata = CSR_DATA_W'(cfg_ff.max_frame_len);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sof_char      <= 8'd2;
         cfg_ff.eof_char      <= 8'd3;
         cfg_ff.esc_char      <= 8'd27;
         cfg_ff.legal_low     <= 8'd0;
         cfg_ff.legal_high    <= 8'd255;
         cfg_ff.max_frame_len <= 16'd256;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   efd_front u_front (
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   efd_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   efd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .entry         (pop_data),
      .queue_empty   (queue_empty),
      .pop           (pop),
      .max_frame_len (cfg_ff.max_frame_len),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data)
   );

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder testbench
// Walks a short table of hand-checked bytes, then random framed traffic under a series
// of register settings, with random gaps on the input side and random stalls on the
// result side. Results are checked against the table or a local decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import efd_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_COUNT    = 8;
   localparam int PHASE_ITEMS    = 48;

   // how a table row is checked; register rows carry index in rx_byte, value in length
   typedef enum logic [1:0] {
      ROW_NONE    = 2'd0,
      ROW_RESULT  = 2'd1,
      ROW_PREDICT = 2'd2,
      ROW_CSR     = 2'd3
   } row_mode_type;

   typedef struct packed {
      row_mode_type mode;
      logic [7:0]   rx_byte;
      logic         line_error;
      kind_type     kind;
      logic [7:0]   payload;
      logic [15:0]  length;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // decoder shadow
   cfg_type     regs;
   logic        in_frame;
   logic        esc_pending;
   logic [15:0] byte_count;

   rsp_type result_queue [$];
   int      mismatches = 0;
   int      total_items;
   int      phase_items;
   int      results_seen = 0;
   int      kind_count [3] = '{0, 0, 0};
   int      stall_left;
   int      idle_cycles;
   bit      quiet;

   row_type directed_rows [38] = '{
      '{ROW_NONE,    8'hFF, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_NONE,    8'h5A, 1'b1, KIND_PAYLOAD,  8'h00, 16'd0},  // line error, no frame
      '{ROW_NONE,    8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_RESULT,  8'h03, 1'b0, KIND_COMPLETE, 8'h00, 16'd0},  // empty frame
      '{ROW_NONE,    8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_RESULT,  8'h00, 1'b0, KIND_PAYLOAD,  8'h00, 16'd1},
      '{ROW_NONE,    8'h1B, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_RESULT,  8'h03, 1'b0, KIND_PAYLOAD,  8'h03, 16'd2},  // escaped end char
      '{ROW_RESULT,  8'h02, 1'b0, KIND_PAYLOAD,  8'h02, 16'd3},  // start char inside
      '{ROW_RESULT,  8'hFF, 1'b0, KIND_PAYLOAD,  8'hFF, 16'd4},
      '{ROW_RESULT,  8'h03, 1'b0, KIND_COMPLETE, 8'h00, 16'd4},
      '{ROW_NONE,    8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_RESULT,  8'hFF, 1'b1, KIND_ABORTED,  8'h00, 16'd0},
      '{ROW_CSR,     8'(REG_LEGAL_LOW),     1'b0, KIND_PAYLOAD, 8'h00, 16'h0020},
      '{ROW_CSR,     8'(REG_LEGAL_HIGH),    1'b0, KIND_PAYLOAD, 8'h00, 16'h007E},
      '{ROW_CSR,     8'(REG_EOF_CHAR),      1'b0, KIND_PAYLOAD, 8'h00, 16'h005C},
      '{ROW_CSR,     8'(REG_ESC_CHAR),      1'b0, KIND_PAYLOAD, 8'h00, 16'h005C},
      '{ROW_CSR,     8'(REG_MAX_FRAME_LEN), 1'b0, KIND_PAYLOAD, 8'h00, 16'd2},
      '{ROW_NONE,    8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},  // opens though illegal
      '{ROW_PREDICT, 8'h41, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_RESULT,  8'h5C, 1'b0, KIND_COMPLETE, 8'h00, 16'd1},  // end beats escape
      '{ROW_NONE,    8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_PREDICT, 8'h41, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_PREDICT, 8'h42, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_RESULT,  8'h43, 1'b0, KIND_ABORTED,  8'h00, 16'd2},  // over length
      '{ROW_CSR,     8'(REG_EOF_CHAR),      1'b0, KIND_PAYLOAD, 8'h00, 16'h007E},
      '{ROW_CSR,     8'(REG_LEGAL_LOW),     1'b0, KIND_PAYLOAD, 8'h00, 16'h0080},
      '{ROW_CSR,     8'(REG_LEGAL_HIGH),    1'b0, KIND_PAYLOAD, 8'h00, 16'h007F},
      '{ROW_CSR,     8'(REG_MAX_FRAME_LEN), 1'b0, KIND_PAYLOAD, 8'h00, 16'd0},
      '{ROW_NONE,    8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_RESULT,  8'h41, 1'b0, KIND_ABORTED,  8'h00, 16'd0},  // empty legal range
      '{ROW_CSR,     8'(REG_LEGAL_LOW),     1'b0, KIND_PAYLOAD, 8'h00, 16'h0020},
      '{ROW_CSR,     8'(REG_LEGAL_HIGH),    1'b0, KIND_PAYLOAD, 8'h00, 16'h007E},
      '{ROW_NONE,    8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_NONE,    8'h5C, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_RESULT,  8'h10, 1'b0, KIND_ABORTED,  8'h00, 16'd0},  // escaped illegal
      '{ROW_NONE,    8'h02, 1'b0, KIND_PAYLOAD,  8'h00, 16'd0},
      '{ROW_RESULT,  8'h41, 1'b0, KIND_ABORTED,  8'h00, 16'd0}   // zero length limit
   };

   escaped_frame_decoder u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // --- decoder shadow ------------------------------------------------------

   function automatic bit frame_drop(output rsp_type res);
      res = '{kind: KIND_ABORTED, payload: 8'h00, frame_length: byte_count};
      in_frame    = 1'b0;
      esc_pending = 1'b0;
      byte_count  = '0;
      return 1'b1;
   endfunction

   function automatic bit frame_take(input logic [7:0] b, output rsp_type res);
      if (byte_count < regs.max_frame_len) begin
         esc_pending = 1'b0;
         byte_count  = byte_count + 16'd1;
         res = '{kind: KIND_PAYLOAD, payload: b, frame_length: byte_count};
         return 1'b1;
      end
      return frame_drop(res);
   endfunction

   function automatic bit decode_byte(input req_type item, output rsp_type res);
      logic [7:0] b;
      b   = item.rx_byte;
      res = '0;
      if (item.line_error) begin
         if (in_frame)
            return frame_drop(res);
         esc_pending = 1'b0;
         byte_count  = '0;
         return 1'b0;
      end
      if (!in_frame) begin
         if (b == regs.sof_char) begin
            in_frame    = 1'b1;
            esc_pending = 1'b0;
            byte_count  = '0;
         end
         return 1'b0;
      end
      if (b < regs.legal_low || b > regs.legal_high)
         return frame_drop(res);
      if (esc_pending)
         return frame_take(b, res);
      if (b == regs.eof_char) begin
         res = '{kind: KIND_COMPLETE, payload: 8'h00, frame_length: byte_count};
         in_frame    = 1'b0;
         esc_pending = 1'b0;
         byte_count  = '0;
         return 1'b1;
      end
      if (b == regs.esc_char) begin
         esc_pending = 1'b1;
         return 1'b0;
      end
      return frame_take(b, res);
   endfunction

   // --- stimulus helpers ----------------------------------------------------

   function automatic int gap_cycles();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // bias towards the special characters and the edges of the legal range
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: return regs.sof_char;
         1: return regs.eof_char;
         2: return regs.esc_char;
         3: return regs.legal_low;
         4: return regs.legal_high;
         default: begin
            if (regs.legal_low <= regs.legal_high)
               return 8'($urandom_range(regs.legal_low, regs.legal_high));
            return 8'($urandom);
         end
      endcase
   endfunction

   task automatic send_item(input req_type item, input row_mode_type mode,
                            input rsp_type typed);
      int      gap;
      rsp_type predicted;
      bit      produced;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? gap_cycles() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      produced = decode_byte(item, predicted);
      if (mode == ROW_RESULT)
         result_queue.push_back(typed);
      else if (mode == ROW_PREDICT && produced)
         result_queue.push_back(predicted);
      total_items++;
      phase_items++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (result_queue.size() != 0) @(posedge clock);
      // bytes with no result may still sit in the queue and engine
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] idx,
                             input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(1'b1, idx, value, unused);
      case (idx)
         REG_SOF_CHAR:      regs.sof_char      = value[7:0];
         REG_EOF_CHAR:      regs.eof_char      = value[7:0];
         REG_ESC_CHAR:      regs.esc_char      = value[7:0];
         REG_LEGAL_LOW:     regs.legal_low     = value[7:0];
         REG_LEGAL_HIGH:    regs.legal_high    = value[7:0];
         REG_MAX_FRAME_LEN: regs.max_frame_len = value[15:0];
         default: ;  // outside the map: ignored
      endcase
   endtask

   task automatic verify_regs();
      logic [31:0]   rd;
      logic [31:0]   want;
      reg_index_type idx;
      for (int r = 0; r <= REG_MAX_FRAME_LEN; r++) begin
         idx = reg_index_type'(r);
         csr_access(1'b0, idx, 32'h0, rd);
         case (idx)
            REG_SOF_CHAR:   want = {24'h0, regs.sof_char};
            REG_EOF_CHAR:   want = {24'h0, regs.eof_char};
            REG_ESC_CHAR:   want = {24'h0, regs.esc_char};
            REG_LEGAL_LOW:  want = {24'h0, regs.legal_low};
            REG_LEGAL_HIGH: want = {24'h0, regs.legal_high};
            default:        want = {16'h0, regs.max_frame_len};
         endcase
         if (rd !== want) begin
            mismatches++;
            $display("%0t: register %s read back: expected %08h, got %08h",
                     $time, idx.name(), want, rd);
         end
      end
   endtask

   task automatic configure(input int p);
      logic [7:0]  s, e, x, lo, hi, t;
      logic [15:0] m;
      case (p)
         0: begin s = 8'd2; e = 8'd3; x = 8'd27; lo = 8'd0; hi = 8'd255; m = 16'd256; end
         1: begin s = 8'd0; e = 8'd255; x = 8'd128; lo = 8'd0; hi = 8'd255; m = 16'hFFFF; end
         2: begin s = 8'd255; e = 8'd0; x = 8'd255; lo = 8'd0; hi = 8'd255; m = 16'd1; end
         3: begin
            lo = 8'h20; hi = 8'h7E; m = 16'd4;
            s = 8'($urandom_range(lo, hi));
            e = 8'($urandom_range(lo, hi));
            x = 8'($urandom_range(lo, hi));
         end
         default: begin
            s  = 8'($urandom); e = 8'($urandom); x = 8'($urandom);
            lo = 8'($urandom_range(0, 80));
            hi = 8'($urandom_range(170, 255));
            if ($urandom_range(0, 4) == 0) begin
               t = lo; lo = hi; hi = t;
            end
            m = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 10));
         end
      endcase
      write_reg(REG_SOF_CHAR, 32'(s));
      write_reg(REG_EOF_CHAR, 32'(e));
      write_reg(REG_ESC_CHAR, 32'(x));
      write_reg(REG_LEGAL_LOW, 32'(lo));
      write_reg(REG_LEGAL_HIGH, 32'(hi));
      write_reg(REG_MAX_FRAME_LEN, 32'(m));
      if (p == 4) begin
         write_reg(3'd6, $urandom);
         write_reg(3'd7, $urandom);
      end
      verify_regs();
   endtask

   // one frame, mostly well formed, or a short run of line noise
   task automatic send_burst();
      int unsigned len;
      int unsigned n;
      logic [7:0]  b;
      if ($urandom_range(0, 99) < 12) begin
         n = $urandom_range(1, 4);
         repeat (n) send_item({8'($urandom), 1'($urandom_range(0, 5) == 0)}, ROW_PREDICT, '0);
         return;
      end
      if ($urandom_range(0, 3) == 0)
         send_item({8'($urandom), 1'b0}, ROW_PREDICT, '0);
      send_item({regs.sof_char, 1'b0}, ROW_PREDICT, '0);
      if (regs.max_frame_len <= 12 && $urandom_range(0, 1) == 1)
         len = $urandom_range(0, regs.max_frame_len + 2);
      else
         len = $urandom_range(0, 8);
      for (int unsigned i = 0; i < len; i++) begin
         b = pick_byte();
         if ((b == regs.eof_char || b == regs.esc_char) && $urandom_range(0, 7) != 0)
            send_item({regs.esc_char, 1'b0}, ROW_PREDICT, '0);
         send_item({b, 1'b0}, ROW_PREDICT, '0);
      end
      n = $urandom_range(0, 99);
      if (n < 72)
         send_item({regs.eof_char, 1'b0}, ROW_PREDICT, '0);
      else if (n < 82 || (n < 92 && regs.legal_low == 0 && regs.legal_high == 8'hFF))
         send_item({8'($urandom), 1'b1}, ROW_PREDICT, '0);
      else if (n < 92) begin
         if (regs.legal_low != 0)
            b = 8'($urandom_range(0, regs.legal_low - 1));
         else
            b = 8'($urandom_range(regs.legal_high + 1, 255));
         send_item({b, 1'b0}, ROW_PREDICT, '0);
      end
      // otherwise the frame runs on into the next burst
   endtask

   // --- result side ---------------------------------------------------------

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            results_seen++;
            if (rsp_data.kind <= KIND_ABORTED)
               kind_count[rsp_data.kind]++;
            if (result_queue.size() == 0) begin
               mismatches++;
               $display("%0t: expected no result, got kind %0d payload %02h length %0d",
                        $time, rsp_data.kind, rsp_data.payload, rsp_data.frame_length);
            end else begin
               want = result_queue.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.payload !== want.payload ||
                   rsp_data.frame_length !== want.frame_length) begin
                  mismatches++;
                  $display("%0t: expected kind %0d payload %02h length %0d,",
                           $time, want.kind, want.payload, want.frame_length);
                  $display("%0t:      got kind %0d payload %02h length %0d",
                           $time, rsp_data.kind, rsp_data.payload, rsp_data.frame_length);
               end
            end
         end
         if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0)
            stall_left = gap_cycles();
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0)
            stall_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                  $time, idle_cycles, result_queue.size());
         $display("** escaped_frame_decoder: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // --- sequence ------------------------------------------------------------

   initial begin
      row_type row;
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      quiet       = 1'b0;
      total_items = 0;
      phase_items = 0;
      regs        = '{sof_char: 8'd2, eof_char: 8'd3, esc_char: 8'd27, legal_low: 8'd0,
                      legal_high: 8'd255, max_frame_len: 16'd256};
      in_frame    = 1'b0;
      esc_pending = 1'b0;
      byte_count  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      verify_regs();

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.mode == ROW_CSR) begin
            wait_idle();
            write_reg(row.rx_byte[2:0], {16'h0, row.length});
         end else begin
            send_item({row.rx_byte, row.line_error}, row.mode,
                      '{kind: row.kind, payload: row.payload, frame_length: row.length});
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         configure(p);
         quiet       = (p == 0 || p == 5);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) send_burst();
      end
      quiet = 1'b0;
      wait_idle();

      $display("%0d bytes decoded across %0d register settings plus the hand-checked table",
               total_items, PHASE_COUNT);
      $display("%0d results: %0d payload, %0d complete, %0d aborted",
               results_seen, kind_count[KIND_PAYLOAD], kind_count[KIND_COMPLETE],
               kind_count[KIND_ABORTED]);
      if (mismatches == 0)
         $display("** escaped_frame_decoder: PASSED **");
      else
         $display("** escaped_frame_decoder: FAILED **");
      $finish;
   end

endmodule
